/* rtl/i2cs_pkg.sv */
`timescale 1ns / 1ps

package i2cs_pkg;

   typedef enum logic [2:0] {
      PH_COUNT  = 3'd0,
      PH_ADDR   = 3'd1,
      PH_DATA   = 3'd2,
      PH_LETTER = 3'd3,
      PH_BIT    = 3'd4,
      PH_SET    = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_DATA  = 3'd1,
      OP_STOP  = 3'd2,
      OP_PORT  = 3'd3,
      OP_END   = 3'd4
   } op_type;

   localparam logic [7:0] COUNT_END  = 8'h00;
   localparam logic [7:0] COUNT_PORT = 8'hFF;
   localparam logic [7:0] LETTER_B   = 8'h42;
   localparam logic [7:0] LETTER_C   = 8'h43;
   localparam logic [7:0] LETTER_D   = 8'h44;

   localparam logic [1:0] PORT_B = 2'd0;
   localparam logic [1:0] PORT_C = 2'd1;
   localparam logic [1:0] PORT_D = 2'd2;

   localparam int NUM_PORTS = 3;

   // one queued command; a stop result follows it when with_stop is set
   typedef struct packed {
      op_type     op;
      logic [7:0] byte_value;
      logic [1:0] port_index;
      logic [7:0] port_value;
      logic       with_stop;
   } entry_type;

endpackage

/* rtl/i2cs_req_if.sv */
`timescale 1ns / 1ps

interface i2cs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] table_byte;

   modport source (output valid, output table_byte, input ready);
   modport sink   (input valid, input table_byte, output ready);
endinterface

/* rtl/i2cs_rsp_if.sv */
`timescale 1ns / 1ps

interface i2cs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [7:0] byte_value;
   logic [1:0] port_index;
   logic [7:0] port_value;
   logic       last;

   modport source (output valid, output op, output byte_value, output port_index,
                   output port_value, output last, input ready);
   modport sink   (input valid, input op, input byte_value, input port_index,
                   input port_value, input last, output ready);
endinterface

/* rtl/i2cs_front.sv */
`timescale 1ns / 1ps

module i2cs_front (
   input  logic                clock,
   input  logic                reset,
   i2cs_req_if.sink            req_ch,
   input  logic                push_ready,
   output logic                push_valid,
   output i2cs_pkg::entry_type push_data
);
   import i2cs_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] letter_ff, letter_in;
   logic [7:0] bit_ff, bit_in;
   logic [7:0] image_ff [NUM_PORTS];
   logic [7:0] image_in [NUM_PORTS];

   logic       accept;
   logic [7:0] b;
   logic [7:0] rem_dec;
   logic       letter_known;
   logic [1:0] idx;
   logic [7:0] cur_image;
   logic [7:0] mask;
   logic [7:0] new_image;

   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;
   assign b            = req_ch.table_byte;
   assign rem_dec      = remaining_ff - 8'd1;

   always_comb begin
      letter_known = 1'b1;
      idx          = PORT_B;
      case (letter_ff)
         LETTER_B: idx = PORT_B;
         LETTER_C: idx = PORT_C;
         LETTER_D: idx = PORT_D;
         default:  letter_known = 1'b0;
      endcase
   end

   always_comb begin
      case (idx)
         PORT_C:  cur_image = image_ff[1];
         PORT_D:  cur_image = image_ff[2];
         default: cur_image = image_ff[0];
      endcase
   end

   assign mask      = 8'd1 << bit_ff[2:0];
   assign new_image = (b != 8'd0) ? (cur_image | mask) : (cur_image & ~mask);

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      letter_in    = letter_ff;
      bit_in       = bit_ff;
      for (int i = 0; i < NUM_PORTS; i++) image_in[i] = image_ff[i];
      push_valid   = 1'b0;
      push_data    = '{op: OP_END, byte_value: 8'd0, port_index: 2'd0,
                       port_value: 8'd0, with_stop: 1'b0};
      if (accept) begin
         case (phase_ff)
            PH_COUNT: begin
               if (b == COUNT_END) begin
                  push_valid = 1'b1;
               end else if (b == COUNT_PORT) begin
                  phase_in = PH_LETTER;
               end else begin
                  remaining_in = b;
                  phase_in     = PH_ADDR;
               end
            end
            PH_ADDR, PH_DATA: begin
               remaining_in         = rem_dec;
               push_valid           = 1'b1;
               push_data.op         = (phase_ff == PH_ADDR) ? OP_START : OP_DATA;
               push_data.byte_value = b;
               if (rem_dec == 8'd0) begin
                  push_data.with_stop = 1'b1;
                  phase_in            = PH_COUNT;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_LETTER: begin
               letter_in = b;
               phase_in  = PH_BIT;
            end
            PH_BIT: begin
               bit_in   = b;
               phase_in = PH_SET;
            end
            PH_SET: begin
               phase_in = PH_COUNT;
               // bad letter or bit number of 8 or more: silently dropped
               if (letter_known && (bit_ff[7:3] == 5'd0)) begin
                  image_in[idx]        = new_image;
                  push_valid           = 1'b1;
                  push_data.op         = OP_PORT;
                  push_data.port_index = idx;
                  push_data.port_value = new_image;
               end
            end
            default: phase_in = PH_COUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COUNT;
         remaining_ff <= 8'd0;
         letter_ff    <= 8'd0;
         bit_ff       <= 8'd0;
         for (int i = 0; i < NUM_PORTS; i++) image_ff[i] <= 8'd0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         letter_ff    <= letter_in;
         bit_ff       <= bit_in;
         for (int i = 0; i < NUM_PORTS; i++) image_ff[i] <= image_in[i];
      end
   end

endmodule

/* rtl/i2cs_queue.sv */
`timescale 1ns / 1ps

module i2cs_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  i2cs_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output i2cs_pkg::entry_type pop_data
);
   import i2cs_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/i2cs_back.sv */
`timescale 1ns / 1ps

module i2cs_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  i2cs_pkg::entry_type pop_data,
   i2cs_rsp_if.source          rsp_ch
);
   import i2cs_pkg::*;

   logic       valid_ff, valid_in;
   logic       stop_pending_ff, stop_pending_in;
   op_type     op_ff, op_in;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] index_ff, index_in;
   logic [7:0] value_ff, value_in;
   logic       last_ff, last_in;
   logic       slot_free;

   assign slot_free = !valid_ff || rsp_ch.ready;
   // queue waits while a stop is still owed for the previous command
   assign pop_ready = slot_free && !stop_pending_ff;

   always_comb begin
      valid_in        = valid_ff;
      stop_pending_in = stop_pending_ff;
      op_in           = op_ff;
      byte_in         = byte_ff;
      index_in        = index_ff;
      value_in        = value_ff;
      last_in         = last_ff;
      if (slot_free) begin
         if (stop_pending_ff) begin
            valid_in        = 1'b1;
            stop_pending_in = 1'b0;
            op_in           = OP_STOP;
            byte_in         = 8'd0;
            index_in        = 2'd0;
            value_in        = 8'd0;
            last_in         = 1'b1;
         end else if (pop_valid) begin
            valid_in        = 1'b1;
            stop_pending_in = pop_data.with_stop;
            op_in           = pop_data.op;
            byte_in         = pop_data.byte_value;
            index_in        = pop_data.port_index;
            value_in        = pop_data.port_value;
            last_in         = !pop_data.with_stop;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         stop_pending_ff <= 1'b0;
      end else begin
         valid_ff        <= valid_in;
         stop_pending_ff <= stop_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      byte_ff  <= byte_in;
      index_ff <= index_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.op         = op_ff;
   assign rsp_ch.byte_value = byte_ff;
   assign rsp_ch.port_index = index_ff;
   assign rsp_ch.port_value = value_ff;
   assign rsp_ch.last       = last_ff;

endmodule

/* rtl/i2c_script_table_sequencer_core.sv */
`timescale 1ns / 1ps
// path: a result from a taken request goes into the command queue, then into the output register
// throughput: one request per cycle while the command queue has room; the output register
//    sends one result per cycle while rsp_ch.ready holds; a line end sends data, then stop
// reset: synchronous, active high; clears the parse phase, port images, queue and output
module i2c_script_table_sequencer_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   i2cs_req_if.sink   req_ch,
   i2cs_rsp_if.source rsp_ch
);
   import i2cs_pkg::*;

   logic      push_valid;
   logic      push_ready;
   entry_type push_data;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_data;

   i2cs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   i2cs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   i2cs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("command pushed into a full queue");

   a_stop_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.op == OP_STOP)) |-> rsp_ch.last)
      else $error("stop result without last");

   a_stop_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last) |=>
         (rsp_ch.valid && (rsp_ch.op == OP_STOP)))
      else $error("stop did not follow a line end at once");

endmodule
